// File: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: ring depth, command
// codes, channel payloads and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 11;
   localparam int CMD_W = 3;
   localparam int WORD_W = 32;

   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic cfg;    // capacity write, empty the deque
      logic exec;   // take a command: pointers, count, ring write
      logic rd;     // read front and rear slots
      logic load;   // fill the result register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

// File: sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the circular deque: accepts a command or a capacity write,
// steps the ring read and loads the result register when it is free.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  cdq_pkg::dp_stat_type stat,
   output cdq_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            // capacity write wins over a command in the same cycle
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.cfg = 1'b1;
            end else if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register can take the new result
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath of the circular deque: ring memory, front and rear pointers,
// held count, capacity register and the result register.
// ----------------------------------------------------------------------------
module cdq_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  cdq_pkg::ctl_cmd_type         cmd,
   output cdq_pkg::dp_stat_type         stat,
   input  cdq_pkg::req_type             req_payload,
   input  logic [cdq_pkg::CAP_W-1:0]    csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cdq_pkg::rsp_type             rsp_payload
);

   logic [cdq_pkg::WORD_W-1:0] ring_mem [cdq_pkg::DEPTH];

   logic [cdq_pkg::IDX_W-1:0]  front_ff, front_in;
   logic [cdq_pkg::IDX_W-1:0]  rear_ff, rear_in;
   logic [cdq_pkg::CNT_W-1:0]  held_ff, held_in;
   logic [cdq_pkg::CNT_W-1:0]  cap_ff, cap_in;
   logic                       ok_ff, ok_in;
   logic [cdq_pkg::WORD_W-1:0] rd_front_ff, rd_rear_ff;
   logic                       rsp_valid_ff;
   cdq_pkg::rsp_type           rsp_ff;

   logic [cdq_pkg::CNT_W-1:0]  front_ext, rear_ext, front_inc, rear_inc;
   logic [cdq_pkg::IDX_W-1:0]  front_dec, rear_dec, front_nxt, rear_last;
   logic [cdq_pkg::IDX_W-1:0]  cap_last;
   logic                       not_full, not_empty;
   logic                       mem_we;
   logic [cdq_pkg::IDX_W-1:0]  mem_wa;
   logic                       held_zero;

   // ring pointer arithmetic over the capacity in use
   always_comb begin
      cap_last  = cdq_pkg::IDX_W'(cap_ff - cdq_pkg::CNT_W'(1));
      front_ext = cdq_pkg::CNT_W'(front_ff);
      rear_ext  = cdq_pkg::CNT_W'(rear_ff);
      front_inc = front_ext + cdq_pkg::CNT_W'(1);
      rear_inc  = rear_ext + cdq_pkg::CNT_W'(1);
      front_dec = (front_ff == '0) ? cap_last : front_ff - cdq_pkg::IDX_W'(1);
      rear_dec  = (rear_ff == '0) ? cap_last : rear_ff - cdq_pkg::IDX_W'(1);
      front_nxt = (front_inc >= cap_ff) ? '0 : front_inc[cdq_pkg::IDX_W-1:0];
      not_full  = held_ff < cap_ff;
      not_empty = held_ff != '0;
      rear_last = rear_dec;
   end

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      held_in  = held_ff;
      cap_in   = cap_ff;
      ok_in    = ok_ff;
      mem_we   = 1'b0;
      mem_wa   = rear_ff;
      if (cmd.cfg) begin
         if (csr_data == '0) begin
            cap_in = cdq_pkg::CNT_W'(1);
         end else if (32'(csr_data) > cdq_pkg::DEPTH) begin
            cap_in = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
         end else begin
            cap_in = cdq_pkg::CNT_W'(csr_data);
         end
         front_in = '0;
         rear_in  = '0;
         held_in  = '0;
      end else if (cmd.exec) begin
         ok_in = 1'b0;
         unique case (req_payload.command)
            cdq_pkg::CMD_QUERY: begin
               ok_in = 1'b1;
            end
            cdq_pkg::CMD_PUSH_FRONT: begin
               if (not_full) begin
                  front_in = front_dec;
                  mem_we   = 1'b1;
                  mem_wa   = front_dec;
                  held_in  = held_ff + cdq_pkg::CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            cdq_pkg::CMD_PUSH_REAR: begin
               if (not_full) begin
                  mem_we  = 1'b1;
                  mem_wa  = rear_ff;
                  rear_in = (rear_inc >= cap_ff) ? '0 : rear_inc[cdq_pkg::IDX_W-1:0];
                  held_in = held_ff + cdq_pkg::CNT_W'(1);
                  ok_in   = 1'b1;
               end
            end
            cdq_pkg::CMD_POP_FRONT: begin
               if (not_empty) begin
                  front_in = front_nxt;
                  held_in  = held_ff - cdq_pkg::CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            cdq_pkg::CMD_POP_REAR: begin
               if (not_empty) begin
                  rear_in = rear_dec;
                  held_in = held_ff - cdq_pkg::CNT_W'(1);
                  ok_in   = 1'b1;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         held_ff  <= '0;
         cap_ff   <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         held_ff  <= held_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   // ring memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wa] <= req_payload.push_value;
      end
      if (cmd.rd) begin
         rd_front_ff <= ring_mem[front_ff];
         rd_rear_ff  <= ring_mem[rear_last];
      end
   end

   assign held_zero = held_ff == '0;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.accepted    <= ok_ff;
         rsp_ff.front_value <= held_zero ? '1 : rd_front_ff;
         rsp_ff.rear_value  <= held_zero ? '1 : rd_rear_ff;
         rsp_ff.is_empty    <= held_zero;
         rsp_ff.is_full     <= held_ff == cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

`ifndef SYNTH
   logic [cdq_pkg::CNT_W:0] chk_sum;
   logic [cdq_pkg::CNT_W:0] chk_rear;

   assign chk_sum  = (cdq_pkg::CNT_W+1)'(front_ff) + (cdq_pkg::CNT_W+1)'(held_ff);
   assign chk_rear = (chk_sum >= (cdq_pkg::CNT_W+1)'(cap_ff))
                   ? chk_sum - (cdq_pkg::CNT_W+1)'(cap_ff) : chk_sum;

   a_held_in_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff)
      else $error("held count above capacity");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      cdq_pkg::CNT_W'(front_ff) < cap_ff && cdq_pkg::CNT_W'(rear_ff) < cap_ff)
      else $error("ring pointer outside capacity");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      chk_rear == (cdq_pkg::CNT_W+1)'(rear_ff))
      else $error("front, rear and count disagree");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

// File: sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a ring memory with a
// programmable capacity in use.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | req_payload (command, push_value)
//   rsp_    | out       | rsp_valid/rsp_ready | rsp_payload (flags, front, rear)
//   csr_    | in        | csr_valid/csr_ready | csr_data (capacity_in_use)
//
// A command runs through transfer with pointer/count update and ring write,
// ring read of front and rear slots, then result load; the ring read is
// registered and comes after the write. The next command is taken while a result
// waits in the output register; a stalled rsp_ holds the sequencer before load.
// Synchronous reset empties the deque and sets capacity to the full depth;
// a capacity write also empties it. No clearing pass.
// ----------------------------------------------------------------------------
module circular_deque (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cdq_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cdq_pkg::rsp_type          rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0] csr_data
);

   cdq_pkg::ctl_cmd_type cmd;
   cdq_pkg::dp_stat_type stat;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
